FILE: hdl/wsa_pkg.sv
// shared types, codes and constants for the worker slot allocator
package wsa_pkg;

    // default pool size and capacity after reset
    localparam int          NUM_SLOTS_DEF = 8;
    localparam int          LOAD_W        = 10;
    localparam logic [9:0]  CAP_RESET     = 10'd1000;

    // result field widths
    localparam int IDX_W = 3;
    localparam int CNT_W = 4;

    // stream widths
    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 2;

    typedef enum logic
    {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } op_e_t;

    typedef enum logic [1:0]
    {
        ST_DONE = 2'd0,
        ST_NONE = 2'd1,
        ST_IDLE = 2'd2
    } status_t;

    // one request as held in the input register
    typedef struct packed
    {
        op_e_t            op;
        logic [IDX_W-1:0] slot;
    } req_t;

    // one result as held in the output register
    typedef struct packed
    {
        status_t           status;
        logic [IDX_W-1:0]  slot_index;
        logic [LOAD_W-1:0] slot_load;
        logic [CNT_W-1:0]  active_count;
    } result_t;

endpackage

FILE: hdl/worker_slot_allocator.sv
// top level of the worker slot allocator
//
//  channel   dir  signals                      contents (low bit up)
//  s_axis    in   tvalid tready tdata tuser    tdata: slot[2:0]; tuser: operation[0]
//  m_axis    out  tvalid tready tdata tuser    tdata: slot_index, slot_load, active_count
//                                              tuser: status[1:0]
//  cfg       in   cfg_wr_en cfg_wr_data        slot_capacity[9:0]
//
//  one request per cycle sustained while the output is not stalled; a taken request goes through
//  the input register, then one pass of search and update into the result register
//  the search is a set of parallel lowest-bit pickers over all slots
//  reset clears all slots, the active count and sets capacity to 1000
//  a stalled output holds its result while one more request waits in the input register
module worker_slot_allocator
    import wsa_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // slot[2:0], zeros above
    input  logic [IN_USER_W-1:0]  s_axis_tuser,   // operation[0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // slot_index[2:0], slot_load[12:3],
                                                  // active_count[16:13], zeros above
    output logic [OUT_USER_W-1:0] m_axis_tuser,   // status[1:0]
    input  logic                  cfg_wr_en,
    input  logic [LOAD_W-1:0]     cfg_wr_data
);

    req_t    in_req;
    req_t    held_req;
    logic    held_valid;
    logic    can_load;
    logic    advance;
    result_t core_res;
    result_t out_res;

    // unpack the request
    assign in_req.op   = op_e_t'(s_axis_tuser[0]);
    assign in_req.slot = s_axis_tdata[IDX_W-1:0];

    // held request moves on when the result register can take it
    assign advance = held_valid && can_load;

    wsa_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_req     (in_req),
        .advance    (advance),
        .held_valid (held_valid),
        .held_req   (held_req)
    );

    wsa_core #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (advance),
        .req         (held_req),
        .result      (core_res)
    );

    wsa_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .result_in (core_res),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .result_q  (out_res),
        .can_load  (can_load)
    );

    // pack the result
    assign m_axis_tdata = {
        (OUT_DATA_W - IDX_W - LOAD_W - CNT_W)'(0),
        out_res.active_count,
        out_res.slot_load,
        out_res.slot_index
    };
    assign m_axis_tuser = out_res.status;

`ifndef SYNTH
    // a waiting request reaches the result register when it has room
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (held_valid && can_load) |=> m_axis_tvalid)
        else $error("held request did not move to the result register");

    // refusals carry no load
    a_refuse_load: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (out_res.status != ST_DONE)) |-> (out_res.slot_load == '0))
        else $error("refused request reports a nonzero load");

    // no slot free only when every slot is active
    a_full_pool: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (out_res.status == ST_NONE))
            |-> (out_res.active_count == CNT_W'(NUM_SLOTS)))
        else $error("no slot reported while some slot is idle");

    // a completed request always leaves a loaded or emptied slot consistent
    a_done_acquire: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (out_res.status == ST_DONE) && (out_res.active_count == '0)
            && (out_res.slot_load != '0)) |-> (CNT_W'(NUM_SLOTS) == '0))
        else $error("loaded slot reported with no active slots");
`endif

endmodule

FILE: hdl/wsa_in_reg.sv
// input register for allocator requests
module wsa_in_reg
    import wsa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_req,
    input  logic advance,
    output logic held_valid,
    output req_t held_req
);

    logic valid_reg;
    logic valid_next;
    req_t req_reg;

    // free slot or draining this cycle
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    // control flop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload flop
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_req;
        end
    end

    assign held_valid = valid_reg;
    assign held_req   = req_reg;

endmodule

FILE: hdl/wsa_core.sv
// slot state, capacity register, parallel search and registered update
module wsa_core
    import wsa_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [LOAD_W-1:0] cfg_wr_data,
    input  logic              fire,
    input  req_t              req,
    output result_t           result
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int TOT_W  = $clog2(NUM_SLOTS + 1);

    logic [LOAD_W-1:0]    capacity_reg;
    logic [NUM_SLOTS-1:0] active_reg;
    logic [NUM_SLOTS-1:0] active_next;
    logic [LOAD_W-1:0]    load_reg  [NUM_SLOTS];
    logic [LOAD_W-1:0]    load_next [NUM_SLOTS];
    logic [TOT_W-1:0]     total_reg;
    logic [TOT_W-1:0]     total_next;

    logic                 is_acq;
    logic                 is_rel;
    logic [NUM_SLOTS-1:0] avail;
    logic [NUM_SLOTS-1:0] idle;
    logic [NUM_SLOTS-1:0] avail_oh;
    logic [NUM_SLOTS-1:0] idle_oh;
    logic [NUM_SLOTS-1:0] grant_oh;
    logic [NUM_SLOTS-1:0] open_oh;
    logic [NUM_SLOTS-1:0] rel_oh;
    logic [NUM_SLOTS-1:0] hit_oh;
    logic                 drop;
    logic [SLOT_W-1:0]    hit_idx;
    logic [LOAD_W-1:0]    hit_load;

    // per-slot candidates and release decode
    always_comb
    begin
        is_acq = (req.op == OP_ACQUIRE);
        is_rel = (req.op == OP_RELEASE);
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            avail[i]  = active_reg[i] && (load_reg[i] < capacity_reg);
            idle[i]   = !active_reg[i];
            rel_oh[i] = is_rel && active_reg[i] && (32'(req.slot) == i);
        end
    end

    // lowest set bit picks the slot
    assign avail_oh = avail & (~avail + NUM_SLOTS'(1));
    assign idle_oh  = idle & (~idle + NUM_SLOTS'(1));
    assign grant_oh = is_acq ? avail_oh : '0;
    assign open_oh  = (is_acq && (avail == '0)) ? idle_oh : '0;
    assign hit_oh   = grant_oh | open_oh | rel_oh;

    // per-slot next state
    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            load_next[i]   = load_reg[i];
            active_next[i] = active_reg[i];
            if (grant_oh[i])
            begin
                load_next[i] = load_reg[i] + LOAD_W'(1);
            end
            else if (open_oh[i])
            begin
                load_next[i]   = LOAD_W'(1);
                active_next[i] = 1'b1;
            end
            else if (rel_oh[i])
            begin
                if (load_reg[i] <= LOAD_W'(1))
                begin
                    load_next[i]   = '0;
                    active_next[i] = 1'b0;
                end
                else
                begin
                    load_next[i] = load_reg[i] - LOAD_W'(1);
                end
            end
        end
    end

    // active slot count
    assign drop = |(active_reg & ~active_next);

    always_comb
    begin
        total_next = total_reg;
        if (|open_oh)
        begin
            total_next = total_reg + TOT_W'(1);
        end
        else if (drop && (total_reg != '0))
        begin
            total_next = total_reg - TOT_W'(1);
        end
    end

    // one-hot to index and load of the touched slot
    always_comb
    begin
        hit_idx  = '0;
        hit_load = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (hit_oh[i])
            begin
                hit_idx  = hit_idx | SLOT_W'(i);
                hit_load = hit_load | load_next[i];
            end
        end
    end

    // result fields
    always_comb
    begin
        result.status       = ST_DONE;
        result.slot_index   = IDX_W'(hit_idx);
        result.slot_load    = hit_load;
        result.active_count = CNT_W'(total_next);
        if (is_acq && (hit_oh == '0))
        begin
            result.status = ST_NONE;
        end
        if (is_rel)
        begin
            result.slot_index = req.slot;
            if (rel_oh == '0)
            begin
                result.status = ST_IDLE;
            end
        end
    end

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            capacity_reg <= cfg_wr_data;
        end
    end

    // slot state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            total_reg  <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                load_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            active_reg <= active_next;
            total_reg  <= total_next;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                load_reg[i] <= load_next[i];
            end
        end
    end

endmodule

FILE: hdl/wsa_out_reg.sv
// result register in front of the output stream
module wsa_out_reg
    import wsa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result_in,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t result_q,
    output logic    can_load
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // empty, or emptied by the sink this cycle
    assign can_load = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // control flop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload flop
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid = valid_reg;
    assign result_q  = result_reg;

endmodule

FILE: dv/testbench.sv
// self-checking testbench for the worker slot allocator
`timescale 1ns / 100ps

module testbench;
    import wsa_pkg::*;

    localparam int HALF_PERIOD = 2;
    localparam int POOL        = NUM_SLOTS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTS  = 40;

    // result field positions in m_axis_tdata
    localparam int LOAD_LO = IDX_W;
    localparam int CNT_LO  = IDX_W + LOAD_W;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  cfg_wr_en     = 1'b0;
    logic [LOAD_W-1:0]     cfg_wr_data   = '0;

    // shadow of the pool as the block should hold it
    logic [POOL-1:0]   busy_mark  = '0;
    logic [LOAD_W-1:0] load_count [POOL] = '{default: '0};
    int unsigned       busy_total = 0;
    logic [LOAD_W-1:0] cap_limit  = CAP_RESET;

    // expected results in request order
    result_t pending_results [$];

    bit                gaps_on      = 1'b1;
    int unsigned       hold_left    = 0;
    int unsigned       cycle_count  = 0;
    int unsigned       error_count  = 0;
    int unsigned       results_seen = 0;
    int unsigned       done_count   = 0;
    int unsigned       none_count   = 0;
    int unsigned       idle_count   = 0;
    logic [LOAD_W-1:0] peak_load    = '0;

    worker_slot_allocator #(
        .NUM_SLOTS (POOL)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // slot[2:0], zeros above
        .s_axis_tuser  (s_axis_tuser),   // operation[0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // slot_index[2:0], slot_load[12:3], active_count[16:13]
        .m_axis_tuser  (m_axis_tuser),   // status[1:0]
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    // clock
    always #HALF_PERIOD clk = ~clk;

    // cycle watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, pending_results.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    // apply one request to the shadow pool and return the result it should give
    function automatic result_t predict_allocation(op_e_t op, logic [IDX_W-1:0] slot);
        result_t res;
        bit      granted;
        granted          = 1'b0;
        res.status       = ST_DONE;
        res.slot_index   = '0;
        res.slot_load    = '0;
        res.active_count = '0;
        if (op == OP_ACQUIRE)
        begin
            // lowest busy slot with room left
            for (int i = 0; i < POOL; i++)
            begin
                if (!granted && busy_mark[i] && load_count[i] < cap_limit)
                begin
                    load_count[i]  = load_count[i] + 1'b1;
                    res.slot_index = IDX_W'(i);
                    res.slot_load  = load_count[i];
                    granted        = 1'b1;
                end
            end
            // otherwise open the lowest idle slot
            for (int i = 0; i < POOL; i++)
            begin
                if (!granted && !busy_mark[i])
                begin
                    busy_mark[i]   = 1'b1;
                    load_count[i]  = LOAD_W'(1);
                    busy_total++;
                    res.slot_index = IDX_W'(i);
                    res.slot_load  = LOAD_W'(1);
                    granted        = 1'b1;
                end
            end
            if (!granted)
                res.status = ST_NONE;
        end
        else
        begin
            res.slot_index = slot;
            if (int'(slot) < POOL && busy_mark[slot])
            begin
                if (load_count[slot] != 0)
                    load_count[slot] = load_count[slot] - 1'b1;
                if (load_count[slot] == 0)
                begin
                    busy_mark[slot] = 1'b0;
                    if (busy_total > 0)
                        busy_total--;
                end
                res.slot_load = load_count[slot];
            end
            else
                res.status = ST_IDLE;
        end
        res.active_count = CNT_W'(busy_total);
        return res;
    endfunction

    // a random slot that is busy right now, or any slot if none is
    function automatic logic [IDX_W-1:0] pick_busy_slot();
        int unsigned candidates [$];
        for (int i = 0; i < POOL; i++)
            if (busy_mark[i])
                candidates.push_back(i);
        if (candidates.size() == 0)
            return IDX_W'($urandom_range(0, POOL - 1));
        return IDX_W'(candidates[$urandom_range(0, candidates.size() - 1)]);
    endfunction

    // one line per mismatch, counted
    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("mismatch on %s at result %0d: got %0d, expected %0d",
                     what, results_seen, got, want);
    endtask

    // present one request, hold it until taken, then predict its result
    task automatic send_request(op_e_t op, logic [IDX_W-1:0] slot);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'(slot);
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(predict_allocation(op, slot));
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // capacity is only changed while nothing is in flight
    task automatic write_capacity(logic [LOAD_W-1:0] value);
        wait_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cap_limit    = value;
    endtask

    // reset capacity: open, stack, drain to idle, release idle slots
    task automatic test_fresh_pool();
        send_request(OP_ACQUIRE, 3'd6);
        send_request(OP_ACQUIRE, 3'd1);
        send_request(OP_RELEASE, 3'd0);
        send_request(OP_RELEASE, 3'd0);
        send_request(OP_RELEASE, 3'd5);
        send_request(OP_RELEASE, 3'd7);
        send_request(OP_ACQUIRE, 3'd0);
    endtask

    // capacity of one fills every slot, then nothing is free
    task automatic test_pool_exhaustion();
        write_capacity(10'd1);
        repeat (8) send_request(OP_ACQUIRE, 3'd0);
        send_request(OP_RELEASE, 3'd3);
        send_request(OP_ACQUIRE, 3'd7);
        send_request(OP_RELEASE, 3'd6);
    endtask

    // capacity of zero: every acquire must open an idle slot
    task automatic test_zero_capacity();
        write_capacity(10'd0);
        send_request(OP_RELEASE, 3'd2);
        send_request(OP_RELEASE, 3'd4);
        send_request(OP_ACQUIRE, 3'd5);
        send_request(OP_ACQUIRE, 3'd2);
        send_request(OP_ACQUIRE, 3'd3);
    endtask

    // stack one slot far up under the widest capacity
    task automatic test_load_ceiling();
        write_capacity(10'd1023);
        while (busy_total != 0)
            send_request(OP_RELEASE, pick_busy_slot());
        repeat (250) send_request(OP_ACQUIRE, IDX_W'($urandom_range(0, POOL - 1)));
        send_request(OP_RELEASE, 3'd0);
        send_request(OP_RELEASE, 3'd1);
    endtask

    // random acquires and releases, releases mostly aimed at busy slots
    task automatic test_random_traffic(logic [LOAD_W-1:0] cap, int unsigned count,
                                       int unsigned acquire_pct);
        int unsigned roll;
        write_capacity(cap);
        repeat (count)
        begin
            roll = $urandom_range(1, 100);
            if (roll <= acquire_pct)
                send_request(OP_ACQUIRE, IDX_W'($urandom_range(0, POOL - 1)));
            else if (roll <= acquire_pct + (100 - acquire_pct) * 3 / 4)
                send_request(OP_RELEASE, pick_busy_slot());
            else
                send_request(OP_RELEASE, IDX_W'($urandom_range(0, POOL - 1)));
        end
    endtask

    // back to back traffic with the sink always ready
    task automatic test_steady_stream();
        wait_for_results();
        gaps_on = 1'b0;
        test_random_traffic(10'd2, 50, 60);
    endtask

    // sink side: random stall bursts and ready stretches
    always @(posedge clk)
    begin
        if (!gaps_on)
            m_axis_tready <= 1'b1;
        else if (hold_left == 0)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left      = $urandom_range(1, 18);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                hold_left      = $urandom_range(1, 40);
            end
        end
        else
            hold_left--;
    end

    // compare each delivered result with the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("result with nothing outstanding", m_axis_tuser, 0);
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser != want.status)
                    report_mismatch("status", m_axis_tuser, want.status);
                if (m_axis_tdata[IDX_W-1:0] != want.slot_index)
                    report_mismatch("slot_index", m_axis_tdata[IDX_W-1:0], want.slot_index);
                if (m_axis_tdata[LOAD_LO +: LOAD_W] != want.slot_load)
                    report_mismatch("slot_load", m_axis_tdata[LOAD_LO +: LOAD_W],
                                    want.slot_load);
                if (m_axis_tdata[CNT_LO +: CNT_W] != want.active_count)
                    report_mismatch("active_count", m_axis_tdata[CNT_LO +: CNT_W],
                                    want.active_count);
                // tally what was covered
                case (want.status)
                    ST_DONE: done_count++;
                    ST_NONE: none_count++;
                    default: idle_count++;
                endcase
                if (want.slot_load > peak_load)
                    peak_load = want.slot_load;
            end
        end
    end

    // test sequence
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_fresh_pool();
        test_pool_exhaustion();
        test_zero_capacity();
        test_load_ceiling();
        test_random_traffic(10'd1, 50, 60);
        test_random_traffic(10'd2, 50, 55);
        test_random_traffic(10'd3, 45, 65);
        test_random_traffic(10'd0, 40, 50);
        test_random_traffic(LOAD_W'($urandom_range(4, 1023)), 45, 60);
        test_random_traffic(10'd1023, 45, 70);
        test_random_traffic(10'd5, 45, 50);
        test_steady_stream();

        // drain and allow for the pipeline latency
        wait_for_results();
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 0, pending_results.size());

        $display("checked %0d results: %0d grants or releases, %0d with no slot free,",
                 results_seen, done_count, none_count);
        $display("%0d idle releases; capacities 0 to 1023 exercised, peak load %0d",
                 idle_count, peak_load);
        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
